// ===== design/sev_pkg.sv =====
package sev_pkg;

  localparam int unsigned SIGNAL_SLOTS = 64;
  localparam int unsigned STACK_DEPTH  = 16;
  localparam int unsigned ATOMIC_SLOTS = 256;

  localparam int unsigned SigAw   = (SIGNAL_SLOTS > 1) ? $clog2(SIGNAL_SLOTS) : 1;
  localparam int unsigned StackAw = $clog2(STACK_DEPTH);
  localparam int unsigned SpW     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DivSteps = 48;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  localparam logic [4:0] OP_NOP   = 5'd0;
  localparam logic [4:0] OP_STORE = 5'd1;
  localparam logic [4:0] OP_LDI   = 5'd2;
  localparam logic [4:0] OP_LDQ   = 5'd3;
  localparam logic [4:0] OP_ITEI  = 5'd4;
  localparam logic [4:0] OP_ITEQ  = 5'd5;
  localparam logic [4:0] OP_BNOT  = 5'd6;
  localparam logic [4:0] OP_BAND  = 5'd7;
  localparam logic [4:0] OP_BOR   = 5'd8;
  localparam logic [4:0] OP_BXOR  = 5'd9;
  localparam logic [4:0] OP_EQI   = 5'd10;
  localparam logic [4:0] OP_EQQ   = 5'd11;
  localparam logic [4:0] OP_NEI   = 5'd12;
  localparam logic [4:0] OP_NEQQ  = 5'd13;
  localparam logic [4:0] OP_GTI   = 5'd14;
  localparam logic [4:0] OP_GTQ   = 5'd15;
  localparam logic [4:0] OP_GEI   = 5'd16;
  localparam logic [4:0] OP_GEQ   = 5'd17;
  localparam logic [4:0] OP_LTI   = 5'd18;
  localparam logic [4:0] OP_LTQ   = 5'd19;
  localparam logic [4:0] OP_LEI   = 5'd20;
  localparam logic [4:0] OP_LEQ   = 5'd21;
  localparam logic [4:0] OP_NEGI  = 5'd22;
  localparam logic [4:0] OP_NEGQ  = 5'd23;
  localparam logic [4:0] OP_ADDI  = 5'd24;
  localparam logic [4:0] OP_ADDQ  = 5'd25;
  localparam logic [4:0] OP_SUBI  = 5'd26;
  localparam logic [4:0] OP_SUBQ  = 5'd27;
  localparam logic [4:0] OP_MULI  = 5'd28;
  localparam logic [4:0] OP_MULQ  = 5'd29;
  localparam logic [4:0] OP_DIVI  = 5'd30;
  localparam logic [4:0] OP_DIVQ  = 5'd31;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EXEC  = 1'b1;

  localparam logic [1:0] KIND_STORE = 2'd0;
  localparam logic [1:0] KIND_UNDER = 2'd1;
  localparam logic [1:0] KIND_OVER  = 2'd2;
  localparam logic [1:0] KIND_DIVZ  = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [4:0]  operation;
    logic [31:0] argument;
    logic [5:0]  signal_slot;
    logic [31:0] signal_value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] atomic_index;
    logic       verdict;
  } out_beat_t;

  typedef struct packed {
    logic       start;
    logic [4:0] op;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic        divz;
    logic [31:0] result;
  } alu_rsp_t;

  function automatic logic [31:0] sat_word(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sh7FFFFFFF) r = 32'h7FFF_FFFF;
    else if (v < -64'sh80000000) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== design/sev_alu.sv =====
module sev_alu import sev_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  alu_req_t    req_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] arg_i,
  output alu_rsp_t    rsp_o
);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_FIX  = 4'b1000
  } alu_state_e;

  alu_state_e         state_q, state_d;
  logic               done_q, done_d, divz_q, divz_d;
  logic [31:0]        res_q, res_d;
  logic [4:0]         op_q, op_d;
  logic               neg_q, neg_d;
  logic signed [63:0] prod_q, prod_d;
  logic [31:0]        den_q, den_d;
  logic [31:0]        rem_q, rem_d;
  logic [47:0]        quo_q, quo_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  logic signed [32:0] sa, sb, sdiff, snegv, ssum;
  logic [32:0]        absd;
  logic [31:0]        mag_a, mag_b, simple;
  logic [32:0]        rem_sh;
  logic signed [63:0] rnd, sq;

  always_comb begin
    sa    = {a_i[31], a_i};
    sb    = {b_i[31], b_i};
    sdiff = sa - sb;
    snegv = -sa;
    ssum  = sa + sb;
    absd  = sdiff[32] ? 33'(-sdiff) : 33'(sdiff);
    mag_a = a_i[31] ? -a_i : a_i;
    mag_b = b_i[31] ? -b_i : b_i;
    case (req_i.op)
      OP_BNOT: simple = {31'd0, a_i != 32'hFFFF_FFFF};
      OP_BAND: simple = {31'd0, (a_i & b_i) != 32'd0};
      OP_BOR:  simple = {31'd0, (a_i | b_i) != 32'd0};
      OP_BXOR: simple = {31'd0, (a_i ^ b_i) != 32'd0};
      OP_EQI:  simple = {31'd0, a_i == b_i};
      OP_EQQ:  simple = {31'd0, !arg_i[31] && (absd <= {1'b0, arg_i})};
      OP_NEI:  simple = {31'd0, a_i != b_i};
      OP_NEQQ: simple = {31'd0, arg_i[31] || (absd > {1'b0, arg_i})};
      OP_GTI:  simple = {31'd0, a_i > b_i};
      OP_GTQ:  simple = {31'd0, sa > sb};
      OP_GEI:  simple = {31'd0, a_i >= b_i};
      OP_GEQ:  simple = {31'd0, sa >= sb};
      OP_LTI:  simple = {31'd0, a_i < b_i};
      OP_LTQ:  simple = {31'd0, sa < sb};
      OP_LEI:  simple = {31'd0, a_i <= b_i};
      OP_LEQ:  simple = {31'd0, sa <= sb};
      OP_NEGI: simple = -a_i;
      OP_NEGQ: simple = sat_word({{31{snegv[32]}}, snegv});
      OP_ADDI: simple = a_i + b_i;
      OP_ADDQ: simple = sat_word({{31{ssum[32]}}, ssum});
      OP_SUBI: simple = a_i - b_i;
      OP_SUBQ: simple = sat_word({{31{sdiff[32]}}, sdiff});
      default: simple = 32'd0;
    endcase
    rem_sh = {rem_q, quo_q[47]};
    rnd    = (prod_q + 64'sd32768) >>> 16;
    sq     = neg_q ? -$signed({16'd0, quo_q}) : $signed({16'd0, quo_q});
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    divz_d  = divz_q;
    res_d   = res_q;
    op_d    = op_q;
    neg_d   = neg_q;
    prod_d  = prod_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          op_d   = req_i.op;
          divz_d = 1'b0;
          if (req_i.op == OP_MULI || req_i.op == OP_MULQ) begin
            prod_d  = $signed(a_i) * $signed(b_i);
            state_d = A_MUL;
          end else if (req_i.op == OP_DIVI || req_i.op == OP_DIVQ) begin
            if (b_i == 32'd0) begin
              divz_d = 1'b1;
              res_d  = 32'hFFFF_FFFF;
              done_d = 1'b1;
            end else begin
              neg_d   = (req_i.op == OP_DIVQ) && (a_i[31] ^ b_i[31]);
              den_d   = (req_i.op == OP_DIVQ) ? mag_b : b_i;
              quo_d   = (req_i.op == OP_DIVQ) ? {mag_a, 16'd0} : {16'd0, a_i};
              rem_d   = 32'd0;
              cnt_d   = '0;
              state_d = A_DIV;
            end
          end else begin
            res_d  = simple;
            done_d = 1'b1;
          end
        end
      end
      A_MUL: begin
        res_d   = (op_q == OP_MULQ) ? sat_word(rnd) : prod_q[31:0];
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      A_DIV: begin
        // One quotient bit per cycle, restoring form.
        quo_d = {quo_q[46:0], 1'b0};
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d    = 32'(rem_sh - {1'b0, den_q});
          quo_d[0] = 1'b1;
        end else begin
          rem_d = rem_sh[31:0];
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) state_d = A_FIX;
      end
      A_FIX: begin
        res_d   = (op_q == OP_DIVQ) ? sat_word(sq) : quo_q[31:0];
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    divz_q <= divz_d;
    res_q  <= res_d;
    op_q   <= op_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign rsp_o = '{done: done_q, divz: divz_q, result: res_q};

endmodule

// ===== design/stack_expression_evaluator_core.sv =====
// Stack machine evaluating monitor expressions over sampled signals. A write beat
// (cmd 0) stores a signal word. An execute beat runs one instruction: nop and ite
// end at once, a load pushes the read signal word (zero if unset or out of range),
// an underflow or overflow is reported, a store pops the top into a result beat,
// and the compare, bitwise, add, subtract, negate, multiply and divide instructions
// run in the shared arithmetic unit, whose divider makes one quotient bit per cycle
// and skips iterating on a zero divisor. A beat that reports a result is held in the
// finish state while the previous result beat waits. Stack and signal memories have
// registered reads; ready is low while an instruction is in flight. A result beat
// waits in an output register, and the next input beat is taken meanwhile.
module stack_expression_evaluator_core import sev_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_EXEC = 5'b00100,
    S_WAIT = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [SpW-1:0]    sp_q, sp_d;
  logic [4:0]        op_q;
  logic [31:0]       arg_q;
  logic              ld_zero_q;
  out_beat_t         pend_q, pend_d, out_q;
  logic              out_valid_q;

  logic [31:0]       sig_mem [SIGNAL_SLOTS];
  logic              sig_vld_q [SIGNAL_SLOTS];
  logic [31:0]       sig_rd_q;
  logic              sig_rd_vld_q;
  logic [31:0]       stk_mem [STACK_DEPTH];
  logic [31:0]       rd_a_q, rd_b_q;

  logic              accept, is_load, is_nop, one_pop, sig_we, stk_we;
  logic [SpW-1:0]    pops, sp_m1, sp_m2;
  logic [31:0]       stk_wdata;
  logic [SigAw-1:0]  sig_waddr, sig_raddr;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign is_load    = (in_i.operation == OP_LDI) || (in_i.operation == OP_LDQ);
  assign is_nop     = (in_i.operation == OP_NOP) || (in_i.operation == OP_ITEI) ||
                      (in_i.operation == OP_ITEQ);
  assign one_pop    = (in_i.operation == OP_STORE) || (in_i.operation == OP_BNOT) ||
                      (in_i.operation == OP_NEGI) || (in_i.operation == OP_NEGQ);
  assign pops       = one_pop ? SpW'(1) : SpW'(2);
  assign sp_m1      = sp_q - SpW'(1);
  assign sp_m2      = sp_q - SpW'(2);
  assign sig_we     = accept && (in_i.cmd == CMD_WRITE) &&
                      (32'(in_i.signal_slot) < 32'(SIGNAL_SLOTS));
  assign sig_waddr  = SigAw'(in_i.signal_slot);
  assign sig_raddr  = SigAw'(in_i.argument);

  always_comb begin
    state_d   = state_q;
    sp_d      = sp_q;
    pend_d    = pend_q;
    stk_we    = 1'b0;
    stk_wdata = alu_rsp.result;
    alu_req   = '{start: 1'b0, op: op_q};
    unique case (state_q)
      S_IDLE: begin
        if (accept && in_i.cmd == CMD_EXEC && !is_nop) begin
          if (is_load) begin
            if (sp_q == SpW'(STACK_DEPTH)) begin
              pend_d  = '{result_kind: KIND_OVER, atomic_index: 8'd0, verdict: 1'b0};
              state_d = S_FIN;
            end else begin
              state_d = S_LOAD;
            end
          end else if (sp_q < pops) begin
            pend_d  = '{result_kind: KIND_UNDER, atomic_index: 8'd0, verdict: 1'b0};
            state_d = S_FIN;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_LOAD: begin
        stk_we    = 1'b1;
        stk_wdata = (sig_rd_vld_q && !ld_zero_q) ? sig_rd_q : 32'd0;
        sp_d      = sp_q + SpW'(1);
        state_d   = S_IDLE;
      end
      S_EXEC: begin
        if (op_q == OP_STORE) begin
          sp_d    = sp_m1;
          pend_d  = '{result_kind: KIND_STORE,
                      atomic_index: 8'(arg_q % ATOMIC_SLOTS),
                      verdict: rd_a_q != 32'd0};
          state_d = S_FIN;
        end else begin
          alu_req.start = 1'b1;
          sp_d = ((op_q == OP_BNOT) || (op_q == OP_NEGI) || (op_q == OP_NEGQ)) ? sp_m1 : sp_m2;
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          stk_we = 1'b1;
          sp_d   = sp_q + SpW'(1);
          if (alu_rsp.divz) begin
            pend_d  = '{result_kind: KIND_DIVZ, atomic_index: 8'd0, verdict: 1'b0};
            state_d = S_FIN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SIGNAL_SLOTS; i++) sig_vld_q[i] <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      if (sig_we) sig_vld_q[sig_waddr] <= 1'b1;
      if (state_q == S_FIN && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (accept) begin
      op_q      <= in_i.operation;
      arg_q     <= in_i.argument;
      ld_zero_q <= in_i.argument >= 32'(SIGNAL_SLOTS);
    end
    if (state_q == S_FIN && (!out_valid_q || out_ready_i)) out_q <= pend_q;
  end

  // Signal memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (sig_we) sig_mem[sig_waddr] <= in_i.signal_value;
    sig_rd_q <= sig_mem[sig_raddr];
  end

  always_ff @(posedge clk_i) begin
    sig_rd_vld_q <= sig_vld_q[sig_raddr];
  end

  // Stack memory: one write port, two registered read ports at the top entries.
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[sp_q[StackAw-1:0]] <= stk_wdata;
    rd_a_q <= stk_mem[sp_m1[StackAw-1:0]];
    rd_b_q <= stk_mem[sp_m2[StackAw-1:0]];
  end

  sev_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (rd_a_q),
    .b_i    (rd_b_q),
    .arg_i  (arg_q),
    .rsp_o  (alu_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(STACK_DEPTH)) else $error("stack pointer beyond depth");
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> state_q == S_WAIT) else $error("arithmetic result outside wait");
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN)) else $error("result beat without finish");
`endif

endmodule
